### hdl/epd_pkg.sv
// Shared types and constants for the escaped packet deframer.
`timescale 1ns / 1ps

package epd_pkg;

   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] SYNC_RESET = 8'hA5;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [7:0]  packet_type;
      logic [15:0] payload_length;
      logic        last_of_packet;
      logic        empty_packet;
   } rsp_item_type;

endpackage

### hdl/epd_in_stage.sv
// Input register that holds one received item for the parser.
`timescale 1ns / 1ps

module epd_in_stage
   import epd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output req_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

### hdl/epd_parser.sv
// Frame parser: sync hunt, header decode, escape handling and payload indexing.
`timescale 1ns / 1ps

module epd_parser
   import epd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [7:0]   csr_write_data,
   input  logic         item_valid,
   output logic         item_ready,
   input  req_item_type item,
   output logic         result_valid,
   input  logic         result_ready,
   output rsp_item_type result
);

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic        escape_ff, escape_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sync_ff;

   logic        fire;
   logic        accept_byte;
   logic [7:0]  byte_value;
   logic [16:0] next_count;
   logic        last_byte;

   assign item_ready = result_ready;
   assign fire       = item_valid && result_ready;
   assign next_count = {1'b0, count_ff} + 17'd1;
   assign last_byte  = next_count >= {1'b0, length_ff};

   always_comb begin
      accept_byte = 1'b1;
      byte_value  = item.rx_byte;
      escape_in   = escape_ff;
      if (escape_ff) begin
         escape_in  = 1'b0;
         byte_value = item.rx_byte ^ ESC_XOR;
      end else if (item.rx_byte == ESC_BYTE) begin
         escape_in   = 1'b1;
         accept_byte = 1'b0;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      type_in         = type_ff;
      length_in       = length_ff;
      count_in        = count_ff;
      result_valid    = 1'b0;
      result          = '0;
      result.packet_type    = type_ff;
      result.payload_length = length_ff;
      if (item.kind) begin
         phase_in        = PH_HUNT;
         header_count_in = 2'd0;
         count_in        = '0;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (accept_byte) begin
                  unique case (header_count_ff)
                     2'd0: begin
                        type_in         = byte_value;
                        header_count_in = 2'd1;
                     end
                     2'd1: begin
                        length_in       = {byte_value, 8'h00};
                        header_count_in = 2'd2;
                     end
                     default: begin
                        length_in       = {length_ff[15:8], byte_value};
                        header_count_in = 2'd0;
                        count_in        = '0;
                        if ({length_ff[15:8], byte_value} == 16'd0) begin
                           phase_in              = PH_HUNT;
                           result_valid          = 1'b1;
                           result.payload_length = 16'd0;
                           result.last_of_packet = 1'b1;
                           result.empty_packet   = 1'b1;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end
                  endcase
               end
            end
            PH_DATA: begin
               if (accept_byte) begin
                  result_valid          = 1'b1;
                  result.data_byte      = byte_value;
                  result.byte_index     = count_ff;
                  result.last_of_packet = last_byte;
                  if (last_byte) begin
                     phase_in = PH_HUNT;
                     count_in = '0;
                  end else begin
                     count_in = next_count[15:0];
                  end
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (item.rx_byte == sync_ff) begin
                  phase_in        = PH_HEADER;
                  header_count_in = 2'd0;
               end
            end
         endcase
      end
      result_valid = result_valid && item_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         header_count_ff <= 2'd0;
         escape_ff       <= 1'b0;
         type_ff         <= 8'd0;
         length_ff       <= 16'd0;
         count_ff        <= 16'd0;
         sync_ff         <= SYNC_RESET;
      end else begin
         if (csr_write_enable) begin
            sync_ff <= csr_write_data;
         end
         if (fire) begin
            phase_ff        <= phase_in;
            header_count_ff <= header_count_in;
            type_ff         <= type_in;
            length_ff       <= length_in;
            count_ff        <= count_in;
            if (item.kind) begin
               escape_ff <= 1'b0;
            end else if (phase_ff == PH_HEADER || phase_ff == PH_DATA) begin
               escape_ff <= escape_in;
            end else if (item.rx_byte == sync_ff) begin
               escape_ff <= 1'b0;
            end
         end
      end
   end

endmodule

### hdl/epd_out_stage.sv
// Result register with a skid entry so the parser can produce one more result during a stall.
`timescale 1ns / 1ps

module epd_out_stage
   import epd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff;
   rsp_item_type skid_ff;
   logic         push;
   logic         main_free;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign main_free = !main_valid_ff || out_ready;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      if (main_free) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (push) begin
            main_ff <= in_item;
         end
      end else if (push) begin
         skid_ff <= in_item;
      end
   end

endmodule

### hdl/escaped_packet_deframer_unit.sv
// Top level of the escaped packet deframer.
//
// Received bytes enter on the req_ channel (valid/ready); req_kind high asks
// for a return to sync hunting. Each de-escaped payload byte leaves on the
// rsp_ channel with its index, the packet type, the header length and a last
// flag; a header with length zero gives one result flagged empty_packet.
// The sync byte is set through csr_write_enable and csr_write_data and is
// meant to be written only while no transfer is in flight.
// A byte accepted on req_ passes the input register, the parser step and the
// result register to rsp_valid. Throughput is one byte per cycle while the result
// stage is not stalled, set by the combinational parser step between the two.
// The result stage holds one extra entry, so while the receiver stalls the
// parser keeps taking bytes until it has produced one more result; then the
// input register fills and req_ready drops until a result transfer frees the
// extra entry. Synchronous reset empties all registers, puts the parser into
// sync hunting and sets the sync byte to 0xA5.
`timescale 1ns / 1ps

module escaped_packet_deframer_unit
   import epd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_byte_index,
   output logic [7:0]  rsp_packet_type,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_last_of_packet,
   output logic        rsp_empty_packet
);

   req_item_type req_item;
   req_item_type held_item;
   logic         held_valid;
   logic         held_ready;
   rsp_item_type parsed_item;
   logic         parsed_valid;
   logic         parsed_ready;
   rsp_item_type rsp_item;

   assign req_item.kind    = req_kind;
   assign req_item.rx_byte = req_rx_byte;

   epd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (held_valid),
      .out_ready (held_ready),
      .out_item  (held_item)
   );

   epd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (held_valid),
      .item_ready       (held_ready),
      .item             (held_item),
      .result_valid     (parsed_valid),
      .result_ready     (parsed_ready),
      .result           (parsed_item)
   );

   epd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (parsed_valid),
      .in_ready  (parsed_ready),
      .in_item   (parsed_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_data_byte      = rsp_item.data_byte;
   assign rsp_byte_index     = rsp_item.byte_index;
   assign rsp_packet_type    = rsp_item.packet_type;
   assign rsp_payload_length = rsp_item.payload_length;
   assign rsp_last_of_packet = rsp_item.last_of_packet;
   assign rsp_empty_packet   = rsp_item.empty_packet;

endmodule

### verif/tb.sv
// Self-checking testbench for the escaped packet deframer.
`timescale 1ns / 1ps

module tb
   import epd_pkg::*;
;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 48;

   typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_DATA} parse_phase_type;

   class deframe_tracker_type;
      logic [7:0]      sync_value;
      parse_phase_type phase;
      int unsigned     header_pos;
      bit              escape_armed;
      logic [7:0]      pkt_type;
      logic [15:0]     pkt_length;
      logic [15:0]     rx_count;
      rsp_item_type    payload_due[$];
      int unsigned     errors, transfers, checked, packets, empties, escapes;

      function new();
         sync_value   = SYNC_RESET;
         phase        = PH_HUNT;
         header_pos   = 0;
         escape_armed = 1'b0;
         pkt_type     = '0;
         pkt_length   = '0;
         rx_count     = '0;
      endfunction

      function int pending();
         return payload_due.size();
      endfunction

      function bit unescape(inout logic [7:0] b);
         if (escape_armed) begin
            escape_armed = 1'b0;
            b = b ^ ESC_XOR;
            escapes++;
            return 1'b1;
         end
         if (b == ESC_BYTE) begin
            escape_armed = 1'b1;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void queue_result(logic [7:0] d, logic [15:0] idx, bit last, bit empty);
         rsp_item_type r;
         r.data_byte      = d;
         r.byte_index     = idx;
         r.packet_type    = pkt_type;
         r.payload_length = pkt_length;
         r.last_of_packet = last;
         r.empty_packet   = empty;
         payload_due.push_back(r);
      endfunction

      function void note_transfer(logic kind, logic [7:0] rx);
         logic [7:0] b;
         bit last;
         b = rx;
         transfers++;
         if (kind) begin
            phase        = PH_HUNT;
            header_pos   = 0;
            rx_count     = '0;
            escape_armed = 1'b0;
            return;
         end
         case (phase)
            PH_HEADER: begin
               if (unescape(b)) begin
                  if (header_pos == 0) begin
                     pkt_type   = b;
                     header_pos = 1;
                  end else if (header_pos == 1) begin
                     pkt_length = {b, 8'h00};
                     header_pos = 2;
                  end else begin
                     pkt_length = pkt_length | {8'h00, b};
                     header_pos = 0;
                     rx_count   = '0;
                     if (pkt_length == 16'd0) begin
                        phase = PH_HUNT;
                        queue_result(8'h00, 16'd0, 1'b1, 1'b1);
                     end else begin
                        phase = PH_DATA;
                     end
                  end
               end
            end
            PH_DATA: begin
               if (unescape(b)) begin
                  last = ({1'b0, rx_count} + 17'd1) >= {1'b0, pkt_length};
                  queue_result(b, rx_count, last, 1'b0);
                  if (last) begin
                     phase    = PH_HUNT;
                     rx_count = '0;
                  end else begin
                     rx_count = rx_count + 16'd1;
                  end
               end
            end
            default: begin
               if (b == sync_value) begin
                  phase        = PH_HEADER;
                  header_pos   = 0;
                  escape_armed = 1'b0;
               end
            end
         endcase
      endfunction

      function void check_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", field, want, got);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         checked++;
         if (payload_due.size() == 0) begin
            errors++;
            $error("Result with nothing outstanding: data_byte %0h, byte_index %0d",
                   got.data_byte, got.byte_index);
            return;
         end
         want = payload_due.pop_front();
         check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
         check_field("byte_index", want.byte_index, got.byte_index);
         check_field("packet_type", 16'(want.packet_type), 16'(got.packet_type));
         check_field("payload_length", want.payload_length, got.payload_length);
         check_field("last_of_packet", 16'(want.last_of_packet), 16'(got.last_of_packet));
         check_field("empty_packet", 16'(want.empty_packet), 16'(got.empty_packet));
         if (want.last_of_packet) packets++;
         if (want.empty_packet) empties++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_byte_index;
   logic [7:0]  rsp_packet_type;
   logic [15:0] rsp_payload_length;
   logic        rsp_last_of_packet;
   logic        rsp_empty_packet;

   deframe_tracker_type board;
   req_item_type        rx_stream[$];
   rsp_item_type        seen;
   bit                  idle_on = 1'b1;
   bit                  hold_off_pending = 1'b0;
   int                  sync_settings = 1;
   int                  cycle_count = 0;

   escaped_packet_deframer_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last_of_packet (rsp_last_of_packet),
      .rsp_empty_packet   (rsp_empty_packet)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_item(input logic kind, input logic [7:0] b);
      rx_stream.push_back('{kind: kind, rx_byte: b});
   endfunction

   function automatic void add_coded(input logic [7:0] b);
      if (b == ESC_BYTE || $urandom_range(0, 99) < 10) begin
         add_item(1'b0, ESC_BYTE);
         add_item(1'b0, b ^ ESC_XOR);
      end else begin
         add_item(1'b0, b);
      end
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return ESC_BYTE;
         1: return board.sync_value;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void add_packet(input bit broken);
      logic [15:0] len;
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         len = 16'd0;
      end else if (r < 85) begin
         len = 16'($urandom_range(1, 8));
      end else if (r < 97) begin
         len = 16'($urandom_range(9, 40));
      end else begin
         len = 16'($urandom);
         broken = 1'b1;
      end
      add_item(1'b0, board.sync_value);
      if (broken && $urandom_range(0, 3) == 0) begin
         add_coded(pick_byte());
         add_item(1'b1, 8'($urandom));
         return;
      end
      add_coded(pick_byte());
      add_coded(len[15:8]);
      add_coded(len[7:0]);
      n = broken ? int'($urandom_range(0, 3)) : int'(len);
      for (int i = 0; i < n; i++) add_coded(pick_byte());
      if (broken && (len > 16'd40 || $urandom_range(0, 1) == 1)) add_item(1'b1, 8'($urandom));
   endfunction

   task automatic send_item(input req_item_type it);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= it.kind;
      req_rx_byte <= it.rx_byte;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic flush_stream();
      while (rx_stream.size() != 0) send_item(rx_stream.pop_front());
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_sync(input logic [7:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      board.sync_value = value;
      csr_write_enable <= 1'b0;
      sync_settings++;
   endtask

   task automatic run_random(input int target, input bit squeeze, input bit mid_pause);
      int counted;
      int r;
      int base;
      bit paused;
      counted = 0;
      paused  = 1'b0;
      if (squeeze) begin
         idle_on          = 1'b0;
         hold_off_pending = 1'b1;
      end
      while (counted < target) begin
         r    = $urandom_range(0, 99);
         base = rx_stream.size();
         if (r < 78) begin
            add_packet(1'b0);
         end else if (r < 88) begin
            add_packet(1'b1);
         end else if (r < 95) begin
            repeat ($urandom_range(1, 4)) add_item(1'b0, 8'($urandom));
         end else begin
            add_item(1'b1, 8'($urandom));
         end
         counted += rx_stream.size() - base;
         flush_stream();
         if (squeeze && counted > 80) idle_on = 1'b1;
         if (mid_pause && !paused && counted > target / 2) begin
            wait_results();
            paused = 1'b1;
         end
      end
   endtask

   always begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = idle_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_data_byte, rsp_byte_index, rsp_packet_type, rsp_payload_length,
                     rsp_last_of_packet, rsp_empty_packet};
            board.check_result(seen);
         end
         if (req_valid && req_ready) board.note_transfer(req_kind, req_rx_byte);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A restart while hunting, then an escape byte that must not matter before sync.
      add_item(1'b1, 8'hFF);
      add_item(1'b0, ESC_BYTE);
      add_item(1'b0, SYNC_RESET);
      // Two escape bytes as the type, decoding to 0x5D, two payload bytes at the extremes.
      add_item(1'b0, ESC_BYTE);
      add_item(1'b0, ESC_BYTE);
      add_item(1'b0, 8'h00);
      add_item(1'b0, 8'h02);
      add_item(1'b0, 8'h00);
      add_item(1'b0, 8'hFF);
      // Zero length given through an escaped high byte gives an empty packet.
      add_item(1'b0, SYNC_RESET);
      add_item(1'b0, 8'hFF);
      add_item(1'b0, ESC_BYTE);
      add_item(1'b0, 8'h20);
      add_item(1'b0, 8'h00);
      // Sync value inside the payload, then a restart with an escape pending.
      add_item(1'b0, SYNC_RESET);
      add_item(1'b0, 8'h00);
      add_item(1'b0, 8'h00);
      add_item(1'b0, 8'h03);
      add_item(1'b0, SYNC_RESET);
      add_item(1'b0, ESC_BYTE);
      add_item(1'b0, 8'h5D);
      add_item(1'b0, ESC_BYTE);
      add_item(1'b1, 8'h00);
      add_item(1'b0, 8'hFF);
      // Largest declared length, cut short by a restart.
      add_item(1'b0, SYNC_RESET);
      add_item(1'b0, 8'h80);
      add_item(1'b0, 8'hFF);
      add_item(1'b0, 8'hFF);
      add_item(1'b0, 8'h01);
      add_item(1'b1, 8'h55);
      flush_stream();
      wait_results();

      write_sync(8'h00);
      run_random(150, 1'b1, 1'b0);
      wait_results();

      write_sync(8'hFF);
      idle_on = 1'b0;
      run_random(150, 1'b0, 1'b0);
      idle_on = 1'b1;
      wait_results();

      write_sync(ESC_BYTE);
      run_random(150, 1'b0, 1'b1);
      wait_results();

      write_sync(8'($urandom));
      run_random(220, 1'b0, 1'b0);
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d transfers under %0d sync settings with %0d escapes decoded.",
               board.transfers, sync_settings, board.escapes);
      $display("Checked %0d results, closing %0d packets, %0d of them empty.",
               board.checked, board.packets, board.empties);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/epd_pkg.sv
hdl/epd_in_stage.sv
hdl/epd_parser.sv
hdl/epd_out_stage.sv
hdl/escaped_packet_deframer_unit.sv
verif/tb.sv
